FILE: hdl/aimdcc_pkg.sv
`default_nettype none

package aimdcc_pkg;

   localparam int unsigned THREAD_LIMIT = 1024;
   localparam int unsigned TIME_BITS    = 48;
   localparam int unsigned CEIL_BITS    = 11;
   localparam int unsigned IV_BITS      = 40;
   localparam int unsigned CSR_IDX_BITS = 3;

   localparam logic [CEIL_BITS-1:0] MAXT_RESET  = 11'd8;
   localparam logic [CEIL_BITS-1:0] MAXT_CAP    = CEIL_BITS'(THREAD_LIMIT);
   localparam logic [CEIL_BITS-1:0] CEIL_ONE    = 11'd1;

   localparam logic [IV_BITS-1:0] CONFIRM_RESET   = 40'd100_000_000;
   localparam logic [IV_BITS-1:0] SHRINK_RESET    = 40'd250_000_000;
   localparam logic [IV_BITS-1:0] FLUSH_RESET     = 40'd1_000_000_000;
   localparam logic [IV_BITS-1:0] GROW_FAST_RESET = 40'd1_000_000_000;
   localparam logic [IV_BITS-1:0] GROW_SLOW_RESET = 40'd4_000_000_000;

   localparam logic [CSR_IDX_BITS-1:0] REG_MAX_THREADS = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_CONFIRM     = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_SHRINK      = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_FLUSH       = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_GROW_FAST   = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_GROW_SLOW   = 3'd5;

   localparam logic CMD_SAMPLE     = 1'b0;
   localparam logic CMD_FLUSH_DONE = 1'b1;

   localparam logic [1:0] CHANGE_NONE    = 2'd0;
   localparam logic [1:0] CHANGE_REDUCED = 2'd1;
   localparam logic [1:0] CHANGE_GROWN   = 2'd2;

   typedef struct packed {
      logic [CEIL_BITS-1:0] max_threads;
      logic [IV_BITS-1:0]   confirm_interval;
      logic [IV_BITS-1:0]   shrink_interval;
      logic [IV_BITS-1:0]   flush_interval;
      logic [IV_BITS-1:0]   grow_fast_interval;
      logic [IV_BITS-1:0]   grow_slow_interval;
   } cfg_type;

   typedef struct packed {
      logic                 load;
      logic [CEIL_BITS-1:0] value;
   } max_write_type;

   typedef struct packed {
      logic                 cmd;
      logic                 over_limit;
      logic                 under_limit;
      logic [TIME_BITS-1:0] time_now;
   } sample_type;

   typedef struct packed {
      logic [CEIL_BITS-1:0] ceiling;
      logic [CEIL_BITS-1:0] threshold;
      logic [TIME_BITS-1:0] over_since;
      logic                 episode;
      logic [TIME_BITS-1:0] last_shrink;
      logic [TIME_BITS-1:0] last_grow;
      logic                 flush_pending;
   } state_type;

endpackage

`default_nettype wire

FILE: hdl/aimd_concurrency_ceiling.sv
// An accepted item reaches the rsp_ ports through an input register and a result register.
// Throughput: one item per cycle; req_ready stays high while the result can move on.
// Reset clears both pipeline stages, the controller state and the configuration
// registers to their documented defaults; no clearing pass is needed.
`default_nettype none

module aimd_concurrency_ceiling (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic                                  req_cmd,
   input  wire logic                                  req_over_limit,
   input  wire logic                                  req_under_limit,
   input  wire logic [aimdcc_pkg::TIME_BITS-1:0]      req_time_now,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [aimdcc_pkg::CEIL_BITS-1:0]           rsp_thread_ceiling,
   output logic [1:0]                                 rsp_ceiling_change,
   output logic                                       rsp_flush_request,
   output logic                                       rsp_in_episode,
   input  wire logic                                  csr_we,
   input  wire logic [aimdcc_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  wire logic [aimdcc_pkg::IV_BITS-1:0]        csr_wdata
);

   aimdcc_pkg::cfg_type                 cfg;
   aimdcc_pkg::max_write_type           max_write;
   aimdcc_pkg::sample_type              sample_ff;
   logic                                sample_valid_ff;
   aimdcc_pkg::state_type               state_ff;
   aimdcc_pkg::state_type               state_in;
   aimdcc_pkg::state_type               state_step;
   logic [1:0]                          change;
   logic                                rsp_valid_ff;
   logic [aimdcc_pkg::CEIL_BITS-1:0]    ceiling_out_ff;
   logic [1:0]                          change_out_ff;
   logic                                flush_out_ff;
   logic                                episode_out_ff;
   logic                                advance;
   logic                                req_fire;

   aimdcc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .max_write (max_write)
   );

   aimdcc_step u_step (
      .cfg        (cfg),
      .state      (state_ff),
      .sample     (sample_ff),
      .state_next (state_step),
      .change     (change)
   );

   assign advance   = sample_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !sample_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   // Writing the thread bound restarts the controller from that bound.
   always_comb begin
      state_in = state_ff;
      if (max_write.load) begin
         state_in.ceiling    = max_write.value;
         state_in.threshold  = max_write.value;
         state_in.episode    = 1'b0;
         state_in.over_since = '0;
      end else if (advance) begin
         state_in = state_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_valid_ff         <= 1'b0;
         rsp_valid_ff            <= 1'b0;
         state_ff.ceiling        <= aimdcc_pkg::MAXT_RESET;
         state_ff.threshold      <= aimdcc_pkg::MAXT_RESET;
         state_ff.over_since     <= '0;
         state_ff.episode        <= 1'b0;
         state_ff.last_shrink    <= '0;
         state_ff.last_grow      <= '0;
         state_ff.flush_pending  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_ready) begin
            sample_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         sample_ff.cmd         <= req_cmd;
         sample_ff.over_limit  <= req_over_limit;
         sample_ff.under_limit <= req_under_limit;
         sample_ff.time_now    <= req_time_now;
      end
      if (advance) begin
         ceiling_out_ff <= state_step.ceiling;
         change_out_ff  <= change;
         flush_out_ff   <= state_step.flush_pending;
         episode_out_ff <= state_step.episode;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_thread_ceiling = ceiling_out_ff;
   assign rsp_ceiling_change = change_out_ff;
   assign rsp_flush_request  = flush_out_ff;
   assign rsp_in_episode     = episode_out_ff;

endmodule

`default_nettype wire

FILE: hdl/aimdcc_csr.sv
`default_nettype none

module aimdcc_csr (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      csr_we,
   input  wire logic [aimdcc_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  wire logic [aimdcc_pkg::IV_BITS-1:0]            csr_wdata,
   output aimdcc_pkg::cfg_type                            cfg,
   output aimdcc_pkg::max_write_type                      max_write
);

   aimdcc_pkg::cfg_type                         cfg_ff;
   aimdcc_pkg::cfg_type                         cfg_in;
   logic [aimdcc_pkg::CEIL_BITS-1:0]            max_raw;
   logic [aimdcc_pkg::CEIL_BITS-1:0]            max_clamped;
   logic                                        max_sel;

   // A zero bound becomes one and anything above the limit saturates.
   always_comb begin
      max_raw = csr_wdata[aimdcc_pkg::CEIL_BITS-1:0];
      if (max_raw == '0) begin
         max_clamped = aimdcc_pkg::CEIL_ONE;
      end else if (max_raw > aimdcc_pkg::MAXT_CAP) begin
         max_clamped = aimdcc_pkg::MAXT_CAP;
      end else begin
         max_clamped = max_raw;
      end
   end

   always_comb begin
      cfg_in  = cfg_ff;
      max_sel = 1'b0;
      if (csr_we) begin
         unique case (csr_index)
            aimdcc_pkg::REG_MAX_THREADS: begin
               cfg_in.max_threads = max_clamped;
               max_sel            = 1'b1;
            end
            aimdcc_pkg::REG_CONFIRM:   cfg_in.confirm_interval   = csr_wdata;
            aimdcc_pkg::REG_SHRINK:    cfg_in.shrink_interval    = csr_wdata;
            aimdcc_pkg::REG_FLUSH:     cfg_in.flush_interval     = csr_wdata;
            aimdcc_pkg::REG_GROW_FAST: cfg_in.grow_fast_interval = csr_wdata;
            aimdcc_pkg::REG_GROW_SLOW: cfg_in.grow_slow_interval = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_threads        <= aimdcc_pkg::MAXT_RESET;
         cfg_ff.confirm_interval   <= aimdcc_pkg::CONFIRM_RESET;
         cfg_ff.shrink_interval    <= aimdcc_pkg::SHRINK_RESET;
         cfg_ff.flush_interval     <= aimdcc_pkg::FLUSH_RESET;
         cfg_ff.grow_fast_interval <= aimdcc_pkg::GROW_FAST_RESET;
         cfg_ff.grow_slow_interval <= aimdcc_pkg::GROW_SLOW_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg             = cfg_ff;
   assign max_write.load  = max_sel;
   assign max_write.value = max_clamped;

endmodule

`default_nettype wire

FILE: hdl/aimdcc_step.sv
`default_nettype none

module aimdcc_step (
   input  wire aimdcc_pkg::cfg_type              cfg,
   input  wire aimdcc_pkg::state_type            state,
   input  wire aimdcc_pkg::sample_type           sample,
   output aimdcc_pkg::state_type                 state_next,
   output logic [1:0]                            change
);

   localparam int unsigned TB = aimdcc_pkg::TIME_BITS;

   logic [TB-1:0]                     since_over;
   logic [TB-1:0]                     since_shrink;
   logic [TB-1:0]                     since_grow;
   logic [aimdcc_pkg::CEIL_BITS-1:0]  half;
   logic [aimdcc_pkg::IV_BITS-1:0]    grow_iv;

   always_comb begin
      since_over   = sample.time_now - state.over_since;
      since_shrink = sample.time_now - state.last_shrink;
      since_grow   = sample.time_now - state.last_grow;
      half         = state.ceiling >> 1;
      if (half == '0) begin
         half = aimdcc_pkg::CEIL_ONE;
      end
      grow_iv = (state.ceiling < state.threshold) ? cfg.grow_fast_interval
                                                  : cfg.grow_slow_interval;

      state_next = state;
      change     = aimdcc_pkg::CHANGE_NONE;

      if (sample.cmd == aimdcc_pkg::CMD_FLUSH_DONE) begin
         if (state.flush_pending) begin
            state_next.flush_pending = 1'b0;
            state_next.last_shrink   = sample.time_now;
         end
      end else if (sample.over_limit) begin
         if (!state.episode) begin
            // A zero start time means the over-limit interval has not begun.
            if (state.over_since == '0) begin
               state_next.over_since = sample.time_now;
            end else if (since_over >= TB'(cfg.confirm_interval)) begin
               state_next.episode     = 1'b1;
               state_next.threshold   = half;
               state_next.ceiling     = half;
               state_next.last_shrink = sample.time_now;
               if (state.ceiling != half) begin
                  change = aimdcc_pkg::CHANGE_REDUCED;
               end
            end
         end else if (since_shrink >= TB'(cfg.shrink_interval)) begin
            if (state.ceiling > aimdcc_pkg::CEIL_ONE) begin
               state_next.ceiling     = state.ceiling - aimdcc_pkg::CEIL_ONE;
               state_next.last_shrink = sample.time_now;
               change                 = aimdcc_pkg::CHANGE_REDUCED;
            end else if (!state.flush_pending &&
                         since_shrink >= TB'(cfg.flush_interval)) begin
               state_next.flush_pending = 1'b1;
            end
         end
      end else begin
         state_next.over_since = '0;
         if (sample.under_limit) begin
            state_next.episode = 1'b0;
            if (state.ceiling < cfg.max_threads && since_grow >= TB'(grow_iv)) begin
               state_next.ceiling   = state.ceiling + aimdcc_pkg::CEIL_ONE;
               state_next.last_grow = sample.time_now;
               change               = aimdcc_pkg::CHANGE_GROWN;
            end
         end
      end
   end

endmodule

`default_nettype wire

FILE: sim/aimdcc_checker.sv
`default_nettype none

module aimdcc_checker (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   input  wire logic                                 req_ready,
   input  wire logic                                 req_cmd,
   input  wire logic                                 req_over_limit,
   input  wire logic                                 req_under_limit,
   input  wire logic [aimdcc_pkg::TIME_BITS-1:0]     req_time_now,
   input  wire logic                                 rsp_valid,
   input  wire logic                                 rsp_ready,
   input  wire logic [aimdcc_pkg::CEIL_BITS-1:0]     rsp_thread_ceiling,
   input  wire logic [1:0]                           rsp_ceiling_change,
   input  wire logic                                 rsp_flush_request,
   input  wire logic                                 rsp_in_episode,
   input  wire logic                                 csr_we,
   input  wire logic [aimdcc_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [aimdcc_pkg::IV_BITS-1:0]       csr_wdata,
   output int                                        failures,
   output int                                        pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned TB = aimdcc_pkg::TIME_BITS;

   typedef struct packed {
      logic [aimdcc_pkg::CEIL_BITS-1:0] thread_ceiling;
      logic [1:0]                       ceiling_change;
      logic                             flush_request;
      logic                             in_episode;
   } ceiling_report_type;

   aimdcc_pkg::cfg_type   limits;
   aimdcc_pkg::state_type ctrl;
   ceiling_report_type    predicted_reports[$];
   int                    fail_count = 0;
   int                    waiting = 0;

   assign failures = fail_count;
   assign pending  = waiting;

   function automatic void apply_register(logic [aimdcc_pkg::CSR_IDX_BITS-1:0] idx,
                                          logic [aimdcc_pkg::IV_BITS-1:0] data);
      logic [aimdcc_pkg::CEIL_BITS-1:0] m;
      case (idx)
         aimdcc_pkg::REG_MAX_THREADS: begin
            m = data[aimdcc_pkg::CEIL_BITS-1:0];
            if (m == '0) m = aimdcc_pkg::CEIL_ONE;
            if (m > aimdcc_pkg::MAXT_CAP) m = aimdcc_pkg::MAXT_CAP;
            limits.max_threads = m;
            ctrl.ceiling       = m;
            ctrl.threshold     = m;
            ctrl.episode       = 1'b0;
            ctrl.over_since    = '0;
         end
         aimdcc_pkg::REG_CONFIRM:   limits.confirm_interval   = data;
         aimdcc_pkg::REG_SHRINK:    limits.shrink_interval    = data;
         aimdcc_pkg::REG_FLUSH:     limits.flush_interval     = data;
         aimdcc_pkg::REG_GROW_FAST: limits.grow_fast_interval = data;
         aimdcc_pkg::REG_GROW_SLOW: limits.grow_slow_interval = data;
         default: ;
      endcase
   endfunction

   function automatic ceiling_report_type adjust_ceiling(aimdcc_pkg::sample_type s);
      ceiling_report_type               r;
      logic [TB-1:0]                    since;
      logic [aimdcc_pkg::CEIL_BITS-1:0] half;
      logic [aimdcc_pkg::IV_BITS-1:0]   step_iv;
      r.ceiling_change = aimdcc_pkg::CHANGE_NONE;
      if (s.cmd == aimdcc_pkg::CMD_FLUSH_DONE) begin
         if (ctrl.flush_pending) begin
            ctrl.flush_pending = 1'b0;
            ctrl.last_shrink   = s.time_now;
         end
      end else if (s.over_limit) begin
         if (!ctrl.episode) begin
            since = s.time_now - ctrl.over_since;
            if (ctrl.over_since == '0) begin
               ctrl.over_since = s.time_now;
            end else if (since >= TB'(limits.confirm_interval)) begin
               half = ctrl.ceiling >> 1;
               ctrl.episode   = 1'b1;
               ctrl.threshold = (half == '0) ? aimdcc_pkg::CEIL_ONE : half;
               if (ctrl.ceiling != ctrl.threshold) begin
                  ctrl.ceiling     = ctrl.threshold;
                  r.ceiling_change = aimdcc_pkg::CHANGE_REDUCED;
               end
               ctrl.last_shrink = s.time_now;
            end
         end else begin
            since = s.time_now - ctrl.last_shrink;
            if (since >= TB'(limits.shrink_interval)) begin
               if (ctrl.ceiling > aimdcc_pkg::CEIL_ONE) begin
                  ctrl.ceiling     = ctrl.ceiling - aimdcc_pkg::CEIL_ONE;
                  ctrl.last_shrink = s.time_now;
                  r.ceiling_change = aimdcc_pkg::CHANGE_REDUCED;
               end else if (!ctrl.flush_pending &&
                            since >= TB'(limits.flush_interval)) begin
                  ctrl.flush_pending = 1'b1;
               end
            end
         end
      end else begin
         ctrl.over_since = '0;
         if (s.under_limit) begin
            ctrl.episode = 1'b0;
            if (ctrl.ceiling < limits.max_threads) begin
               step_iv = (ctrl.ceiling < ctrl.threshold) ? limits.grow_fast_interval
                                                          : limits.grow_slow_interval;
               since = s.time_now - ctrl.last_grow;
               if (since >= TB'(step_iv)) begin
                  ctrl.ceiling     = ctrl.ceiling + aimdcc_pkg::CEIL_ONE;
                  ctrl.last_grow   = s.time_now;
                  r.ceiling_change = aimdcc_pkg::CHANGE_GROWN;
               end
            end
         end
      end
      r.thread_ceiling = ctrl.ceiling;
      r.flush_request  = ctrl.flush_pending;
      r.in_episode     = ctrl.episode;
      return r;
   endfunction

   always @(posedge clock) begin
      ceiling_report_type     want;
      ceiling_report_type     fresh;
      aimdcc_pkg::sample_type s;
      if (reset) begin
         limits.max_threads        = aimdcc_pkg::MAXT_RESET;
         limits.confirm_interval   = aimdcc_pkg::CONFIRM_RESET;
         limits.shrink_interval    = aimdcc_pkg::SHRINK_RESET;
         limits.flush_interval     = aimdcc_pkg::FLUSH_RESET;
         limits.grow_fast_interval = aimdcc_pkg::GROW_FAST_RESET;
         limits.grow_slow_interval = aimdcc_pkg::GROW_SLOW_RESET;
         ctrl.ceiling       = aimdcc_pkg::MAXT_RESET;
         ctrl.threshold     = aimdcc_pkg::MAXT_RESET;
         ctrl.over_since    = '0;
         ctrl.episode       = 1'b0;
         ctrl.last_shrink   = '0;
         ctrl.last_grow     = '0;
         ctrl.flush_pending = 1'b0;
         predicted_reports.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_reports.size() == 0) begin
               $error("result with no prediction waiting: thread_ceiling %0d",
                      rsp_thread_ceiling);
               fail_count++;
            end else begin
               want = predicted_reports.pop_front();
               if (rsp_thread_ceiling !== want.thread_ceiling) begin
                  $error("thread_ceiling: expected %0d, actual %0d",
                         want.thread_ceiling, rsp_thread_ceiling);
                  fail_count++;
               end
               if (rsp_ceiling_change !== want.ceiling_change) begin
                  $error("ceiling_change: expected %0d, actual %0d",
                         want.ceiling_change, rsp_ceiling_change);
                  fail_count++;
               end
               if (rsp_flush_request !== want.flush_request) begin
                  $error("flush_request: expected %0d, actual %0d",
                         want.flush_request, rsp_flush_request);
                  fail_count++;
               end
               if (rsp_in_episode !== want.in_episode) begin
                  $error("in_episode: expected %0d, actual %0d",
                         want.in_episode, rsp_in_episode);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            s.cmd         = req_cmd;
            s.over_limit  = req_over_limit;
            s.under_limit = req_under_limit;
            s.time_now    = req_time_now;
            fresh = adjust_ceiling(s);
            predicted_reports.insert(predicted_reports.size(), fresh);
         end
         if (csr_we) apply_register(csr_index, csr_wdata);
      end
      waiting = predicted_reports.size();
   end

endmodule

`default_nettype wire

FILE: sim/tb_aimd_concurrency_ceiling.sv
`default_nettype none

module tb_aimd_concurrency_ceiling;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned TB  = aimdcc_pkg::TIME_BITS;
   localparam int unsigned IVB = aimdcc_pkg::IV_BITS;
   localparam int STALL_LIMIT = 2000;
   localparam logic [IVB-1:0] IV_FULL = '1;
   localparam logic [aimdcc_pkg::CSR_IDX_BITS-1:0] REG_SPARE_LO =
      aimdcc_pkg::REG_GROW_SLOW + 3'd1;
   localparam logic [aimdcc_pkg::CSR_IDX_BITS-1:0] REG_SPARE_HI =
      aimdcc_pkg::REG_GROW_SLOW + 3'd2;

   typedef enum {DRIVE_OVER, DRIVE_UNDER, DRIVE_NOISE} drive_mode_type;

   logic                                  clock = 1'b0;
   logic                                  reset;
   logic                                  req_valid;
   logic                                  req_ready;
   logic                                  req_cmd;
   logic                                  req_over_limit;
   logic                                  req_under_limit;
   logic [TB-1:0]                         req_time_now;
   logic                                  rsp_valid;
   logic                                  rsp_ready;
   logic [aimdcc_pkg::CEIL_BITS-1:0]      rsp_thread_ceiling;
   logic [1:0]                            rsp_ceiling_change;
   logic                                  rsp_flush_request;
   logic                                  rsp_in_episode;
   logic                                  csr_we;
   logic [aimdcc_pkg::CSR_IDX_BITS-1:0]   csr_index;
   logic [IVB-1:0]                        csr_wdata;

   int                      failures;
   int                      pending;
   int                      sent_count = 0;
   bit                      sender_calm = 1'b0;
   logic [TB-1:0]           tick_now = '0;
   int                      quiet_cycles = 0;

   aimd_concurrency_ceiling dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_over_limit     (req_over_limit),
      .req_under_limit    (req_under_limit),
      .req_time_now       (req_time_now),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_thread_ceiling (rsp_thread_ceiling),
      .rsp_ceiling_change (rsp_ceiling_change),
      .rsp_flush_request  (rsp_flush_request),
      .rsp_in_episode     (rsp_in_episode),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   aimdcc_checker ceiling_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_over_limit     (req_over_limit),
      .req_under_limit    (req_under_limit),
      .req_time_now       (req_time_now),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_thread_ceiling (rsp_thread_ceiling),
      .rsp_ceiling_change (rsp_ceiling_change),
      .rsp_flush_request  (rsp_flush_request),
      .rsp_in_episode     (rsp_in_episode),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .failures           (failures),
      .pending            (pending)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("[aimd_concurrency_ceiling] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : receiver
      int stall;
      int served;
      bit calm;
      served = 0;
      calm = 1'b0;
      rsp_ready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if (served % 40 == 0) calm = ($urandom_range(0, 3) == 0);
         stall = calm ? 0 : $urandom_range(0, 13);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         served++;
         @(negedge clock);
      end
   end

   task automatic post_sample(input logic cmd, input logic over, input logic under,
                              input logic [TB-1:0] stamp);
      int gap;
      if (sent_count % 40 == 0) sender_calm = ($urandom_range(0, 3) == 0);
      gap = sender_calm ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_cmd         <= cmd;
      req_over_limit  <= over;
      req_under_limit <= under;
      req_time_now    <= stamp;
      req_valid       <= 1'b1;
      do @(posedge clock); while (!(req_valid && req_ready));
      sent_count++;
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      wait (pending == 0);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [aimdcc_pkg::CSR_IDX_BITS-1:0] idx,
                            input logic [IVB-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   task automatic configure(input logic [IVB-1:0] max_word,
                            input logic [IVB-1:0] confirm,
                            input logic [IVB-1:0] shrink,
                            input logic [IVB-1:0] flush,
                            input logic [IVB-1:0] fast,
                            input logic [IVB-1:0] slow,
                            input bit spare);
      drain_results();
      repeat (3) @(negedge clock);
      write_reg(aimdcc_pkg::REG_MAX_THREADS, max_word);
      write_reg(aimdcc_pkg::REG_CONFIRM, confirm);
      write_reg(aimdcc_pkg::REG_SHRINK, shrink);
      write_reg(aimdcc_pkg::REG_FLUSH, flush);
      write_reg(aimdcc_pkg::REG_GROW_FAST, fast);
      write_reg(aimdcc_pkg::REG_GROW_SLOW, slow);
      if (spare) begin
         write_reg(REG_SPARE_LO, IV_FULL);
         write_reg(REG_SPARE_HI, IV_FULL);
      end
      csr_we <= 1'b0;
   endtask

   task automatic pressure_run(input int count, input logic [63:0] step_max);
      int                   burst;
      int                   roll;
      drive_mode_type       mode;
      logic                 cmd;
      logic                 over;
      logic                 under;
      logic [TB-1:0]        stamp;
      logic [63:0]          stride;
      burst = 0;
      mode = DRIVE_OVER;
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) drain_results();
         if (burst == 0) begin
            burst = $urandom_range(3, 40);
            roll = $urandom_range(0, 4);
            mode = (roll < 2) ? DRIVE_OVER : (roll < 4) ? DRIVE_UNDER : DRIVE_NOISE;
         end
         burst--;
         cmd = ($urandom_range(0, 99) < 6) ? aimdcc_pkg::CMD_FLUSH_DONE
                                           : aimdcc_pkg::CMD_SAMPLE;
         case (mode)
            DRIVE_OVER: begin
               over = 1'b1;
               under = ($urandom_range(0, 4) == 0);
            end
            DRIVE_UNDER: begin
               over = ($urandom_range(0, 19) == 0);
               under = ($urandom_range(0, 9) != 0);
            end
            default: begin
               over = 1'($urandom);
               under = 1'($urandom);
            end
         endcase
         roll = $urandom_range(0, 99);
         stride = {$urandom, $urandom} % (step_max + 64'd1);
         if (roll < 3) begin
            stamp = TB'({$urandom, $urandom});
         end else if (roll < 5) begin
            stamp = '0;
         end else begin
            tick_now = tick_now + stride[TB-1:0];
            stamp = tick_now;
         end
         post_sample(cmd, over, under, stamp);
      end
   endtask

   initial begin : stimulus
      logic [TB-1:0] stamp;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_cmd         = aimdcc_pkg::CMD_SAMPLE;
      req_over_limit  = 1'b0;
      req_under_limit = 1'b0;
      req_time_now    = '0;
      csr_we          = 1'b0;
      csr_index       = aimdcc_pkg::REG_MAX_THREADS;
      csr_wdata       = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset intervals: walk one full episode down to a flush, then grow back.
      stamp = '0;
      post_sample(aimdcc_pkg::CMD_FLUSH_DONE, 1'b1, 1'b1, stamp);
      post_sample(aimdcc_pkg::CMD_SAMPLE, 1'b1, 1'b0, stamp);
      stamp = 48'd1000;
      post_sample(aimdcc_pkg::CMD_SAMPLE, 1'b1, 1'b0, stamp);
      stamp += 48'd100_000_000;
      post_sample(aimdcc_pkg::CMD_SAMPLE, 1'b1, 1'b1, stamp);
      repeat (4) begin
         stamp += 48'd250_000_000;
         post_sample(aimdcc_pkg::CMD_SAMPLE, 1'b1, 1'b0, stamp);
      end
      stamp += 48'd1_000_000_000;
      post_sample(aimdcc_pkg::CMD_SAMPLE, 1'b1, 1'b0, stamp);
      stamp += 48'd1;
      post_sample(aimdcc_pkg::CMD_SAMPLE, 1'b1, 1'b0, stamp);
      stamp += 48'd5;
      post_sample(aimdcc_pkg::CMD_FLUSH_DONE, 1'b1, 1'b0, stamp);
      post_sample(aimdcc_pkg::CMD_FLUSH_DONE, 1'b0, 1'b1, stamp);
      post_sample(aimdcc_pkg::CMD_SAMPLE, 1'b0, 1'b0, stamp);
      repeat (4) begin
         stamp += 48'd1_000_000_000;
         post_sample(aimdcc_pkg::CMD_SAMPLE, 1'b0, 1'b1, stamp);
      end
      post_sample(aimdcc_pkg::CMD_SAMPLE, 1'b0, 1'b1, 48'hFFFF_FFFF_FFFF);
      post_sample(aimdcc_pkg::CMD_SAMPLE, 1'b0, 1'b1, 48'd3_000_000_000);
      post_sample(aimdcc_pkg::CMD_SAMPLE, 1'b0, 1'b1, 48'd4_000_000_000);
      post_sample(aimdcc_pkg::CMD_SAMPLE, 1'b1, 1'b0, 48'hFFFF_FFFF_FFFF);
      post_sample(aimdcc_pkg::CMD_SAMPLE, 1'b1, 1'b0, 48'd99_999_998);
      post_sample(aimdcc_pkg::CMD_SAMPLE, 1'b1, 1'b0, 48'd99_999_999);

      configure(40'd16, 40'd20, 40'd10, 40'd40, 40'd5, 40'd15, 1'b0);
      pressure_run(220, 64'd12);

      configure(40'h7FF, '0, '0, '0, '0, '0, 1'b0);
      pressure_run(220, 64'd3);

      configure(40'd0, IV_FULL, IV_FULL, IV_FULL, IV_FULL, IV_FULL, 1'b0);
      pressure_run(220, 64'h200_0000_0000);

      configure(IVB'($urandom_range(1, 1024)), IVB'($urandom_range(0, 300)),
                IVB'($urandom_range(0, 300)), IVB'($urandom_range(0, 300)),
                IVB'($urandom_range(0, 300)), IVB'($urandom_range(0, 300)), 1'b0);
      pressure_run(220, 64'd100);

      configure(40'd1024, IVB'($urandom_range(0, 20)), IVB'($urandom_range(0, 20)),
                IVB'($urandom_range(0, 20)), IVB'($urandom_range(0, 20)),
                IVB'($urandom_range(0, 20)), 1'b1);
      tick_now = 48'hFFFF_FFFF_FFFF - 48'd1500;
      pressure_run(220, 64'd20);

      configure(IVB'({$urandom, $urandom}), IVB'($urandom_range(0, 4096)),
                IVB'($urandom_range(0, 4096)), IVB'($urandom_range(0, 4096)),
                IVB'($urandom_range(0, 4096)), IVB'($urandom_range(0, 4096)), 1'b0);
      pressure_run(220, 64'd4096);

      req_valid <= 1'b0;
      wait (pending == 0);
      repeat (6) @(negedge clock);
      if (failures == 0 && pending == 0) begin
         $display("[aimd_concurrency_ceiling] OK");
      end else begin
         $display("[aimd_concurrency_ceiling] ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: aimd_concurrency_ceiling.f
hdl/aimdcc_pkg.sv
hdl/aimdcc_csr.sv
hdl/aimdcc_step.sv
hdl/aimd_concurrency_ceiling.sv
sim/aimdcc_checker.sv
sim/tb_aimd_concurrency_ceiling.sv
